/* src/exr_pkg.sv */
// ----------------------------------------------------------------------------
// exr_pkg: shared types, constants and tables for the Euler XYZ rotation unit
// Holds the request and result structs, the fixed-point widths and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package exr_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int DATA_BITS  = 32;
	localparam int COEF_BITS  = 18;
	localparam int FRAC       = COEF_BITS - 2;
	localparam int CORDIC_STEPS = 30;
	// cordic datapath width: 30 fraction bits plus sign and headroom
	localparam int CW = 34;
	localparam int ZW = 33;

	typedef struct packed {
		logic [ANGLE_BITS-1:0]       angle_x;
		logic [ANGLE_BITS-1:0]       angle_y;
		logic [ANGLE_BITS-1:0]       angle_z;
		logic signed [DATA_BITS-1:0] vec_x;
		logic signed [DATA_BITS-1:0] vec_y;
		logic signed [DATA_BITS-1:0] vec_z;
	} req_t;

	typedef struct packed {
		logic signed [DATA_BITS-1:0] out_x;
		logic signed [DATA_BITS-1:0] out_y;
		logic signed [DATA_BITS-1:0] out_z;
		logic                        saturated;
	} res_t;

	// cosine/sine pair, F fraction bits, range [-1,1]
	typedef struct packed {
		logic signed [COEF_BITS-1:0] c;
		logic signed [COEF_BITS-1:0] s;
	} cs_t;

	typedef logic signed [COEF_BITS-1:0] coef_t;

	function automatic logic signed [ZW-1:0] atan_lut(input int i);
		logic [31:0] v;
		case (i)
			0:  v = 32'h20000000; 1:  v = 32'h12E4051E; 2:  v = 32'h09FB385B;
			3:  v = 32'h051111D4; 4:  v = 32'h028B0D43; 5:  v = 32'h0145D7E1;
			6:  v = 32'h00A2F61E; 7:  v = 32'h00517C55; 8:  v = 32'h0028BE53;
			9:  v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
			12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
			15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
			18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
			21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
			24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
			27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
			default: v = 32'h0;
		endcase
		return signed'({1'b0, v});
	endfunction

endpackage

/* src/euler_xyz_vector_rotation_unit.sv */
// ----------------------------------------------------------------------------
// euler_xyz_vector_rotation_unit: rotates a vector by Rx(ax)*Ry(-ay)*Rz(-az)
// Usage:
//   req channel (req_valid/req_ready/req) carries three binary angles and a
//   Q16.16 vector; res channel (res_valid/res_ready/res) returns the rotated,
//   saturated vector and a clip flag.
//   Throughput: one request per cycle, sustained while res_ready stays high.
//   Depth: 36 register stages (32 cordic stages: entry, 30 rotations and
//   fold-back; 2 matrix stages; 2 vector stages), set by the
//   one-rotation-per-stage cordic pipeline; res_valid is the valid bit of
//   the last stage.
//   Reset clears all valid bits; payload registers are not reset.
//   When the receiver stalls the whole pipeline holds (a global enable), so
//   no request is lost or repeated; req_ready follows res_ready whenever the
//   output register is full.
// ----------------------------------------------------------------------------
module euler_xyz_vector_rotation_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  exr_pkg::req_t  req,
	output logic           res_valid,
	input  logic           res_ready,
	output exr_pkg::res_t  res
);
	localparam int LAT = exr_pkg::CORDIC_STEPS + 6;

	logic       en;
	logic [LAT:1] vld_q;
	logic signed [2:0][exr_pkg::DATA_BITS-1:0] vec_q [0:exr_pkg::CORDIC_STEPS+3];
	exr_pkg::cs_t [2:0]        cs;
	exr_pkg::coef_t [2:0][2:0] m;

	// pipeline advances unless the last stage holds an untaken result
	assign en        = !vld_q[LAT] || res_ready;
	assign req_ready = en;
	assign res_valid = vld_q[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-1:1], req_valid};
		end
	end

	// vector rides alongside cordic and matrix stages
	always_ff @(posedge clk) begin
		if (en) begin
			vec_q[0] <= {req.vec_z, req.vec_y, req.vec_x};
			for (int i = 1; i <= exr_pkg::CORDIC_STEPS + 3; i++)
				vec_q[i] <= vec_q[i-1];
		end
	end

	exr_cordic u_cordic (
		.clk    (clk),
		.en     (en),
		.angle  ({req.angle_z, req.angle_y, req.angle_x}),
		.cs     (cs)
	);

	exr_matrix u_matrix (
		.clk (clk),
		.en  (en),
		.cs  (cs),
		.m   (m)
	);

	exr_mvmul u_mvmul (
		.clk (clk),
		.en  (en),
		.m   (m),
		.v   (vec_q[exr_pkg::CORDIC_STEPS+3]),
		.res (res)
	);

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> req_ready)
		else $error("stalled with empty output");
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> vld_q[1])
		else $error("request lost at entry");
`endif
endmodule

/* src/exr_cordic.sv */
// ----------------------------------------------------------------------------
// exr_cordic: pipelined cordic sine/cosine
// One rotation per stage for three angles in parallel, then rounding,
// clamping and quadrant fold-back.
// ----------------------------------------------------------------------------
module exr_cordic (
	input  logic                            clk,
	input  logic                            en,
	input  logic [2:0][exr_pkg::ANGLE_BITS-1:0] angle,
	output exr_pkg::cs_t [2:0]              cs
);
	localparam int N  = exr_pkg::CORDIC_STEPS;
	localparam int CW = exr_pkg::CW;
	localparam int ZW = exr_pkg::ZW;
	localparam int F  = exr_pkg::FRAC;

	logic signed [CW-1:0] x_s [0:N][2:0];
	logic signed [CW-1:0] y_s [0:N][2:0];
	logic signed [ZW-1:0] z_s [0:N][2:0];
	logic [1:0]           q_s [0:N][2:0];

	// stage 0: phase split into quadrant and residual
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				logic [31:0] ph;
				logic [1:0]  qq;
				ph = {angle[a], {(32-exr_pkg::ANGLE_BITS){1'b0}}};
				if (a != 0) ph = 32'd0 - ph;
				qq = 2'((ph + 32'h20000000) >> 30);
				x_s[0][a] <= CW'(34'sh26DD3B6A);
				y_s[0][a] <= '0;
				z_s[0][a] <= ZW'(signed'(ph - {qq, 30'd0}));
				q_s[0][a] <= qq;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (en) begin
				for (int a = 0; a < 3; a++) begin
					if (!z_s[i][a][ZW-1]) begin
						x_s[i+1][a] <= x_s[i][a] - (y_s[i][a] >>> i);
						y_s[i+1][a] <= y_s[i][a] + (x_s[i][a] >>> i);
						z_s[i+1][a] <= z_s[i][a] - exr_pkg::atan_lut(i);
					end else begin
						x_s[i+1][a] <= x_s[i][a] + (y_s[i][a] >>> i);
						y_s[i+1][a] <= y_s[i][a] - (x_s[i][a] >>> i);
						z_s[i+1][a] <= z_s[i][a] + exr_pkg::atan_lut(i);
					end
					q_s[i+1][a] <= q_s[i][a];
				end
			end
		end
	end

	function automatic exr_pkg::coef_t rnd(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] r;
		r = (v + (CW'(1) <<< (29 - F))) >>> (30 - F);
		if (r > CW'(1 <<< F)) r = CW'(1 <<< F);
		if (r < -CW'(1 <<< F)) r = -CW'(1 <<< F);
		return exr_pkg::COEF_BITS'(r);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				exr_pkg::coef_t cc, ss;
				cc = rnd(x_s[N][a]);
				ss = rnd(y_s[N][a]);
				case (q_s[N][a])
					2'd0: begin cs[a].c <= cc;  cs[a].s <= ss;  end
					2'd1: begin cs[a].c <= -ss; cs[a].s <= cc;  end
					2'd2: begin cs[a].c <= -cc; cs[a].s <= -ss; end
					default: begin cs[a].c <= ss; cs[a].s <= -cc; end
				endcase
			end
		end
	end
endmodule

/* src/exr_matrix.sv */
// ----------------------------------------------------------------------------
// exr_matrix: rotation matrix build, M = (Rx*Ry)*Rz, rounded per entry
// Two registered stages.
// ----------------------------------------------------------------------------
module exr_matrix (
	input  logic                        clk,
	input  logic                        en,
	input  exr_pkg::cs_t [2:0]          cs,
	output exr_pkg::coef_t [2:0][2:0]   m
);
	localparam int F  = exr_pkg::FRAC;
	localparam int PW = 2 * exr_pkg::COEF_BITS + 2;

	exr_pkg::coef_t t1_s [3][3];
	exr_pkg::coef_t mz_s [3][3];

	function automatic exr_pkg::coef_t rnd(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] r;
		r = (v + (PW'(1) <<< (F - 1))) >>> F;
		return exr_pkg::COEF_BITS'(r);
	endfunction

	// Rx*Ry has single-product entries
	always_ff @(posedge clk) begin
		if (en) begin
			exr_pkg::coef_t one, cx, sx, cy, sy, cz, sz;
			one = exr_pkg::COEF_BITS'(1 <<< F);
			cx = cs[0].c; sx = cs[0].s; cy = cs[1].c; sy = cs[1].s;
			cz = cs[2].c; sz = cs[2].s;
			t1_s[0][0] <= cy;  t1_s[0][1] <= '0;  t1_s[0][2] <= sy;
			t1_s[1][0] <= rnd(PW'(sx) * PW'(sy));
			t1_s[1][1] <= cx;
			t1_s[1][2] <= rnd(-(PW'(sx) * PW'(cy)));
			t1_s[2][0] <= rnd(-(PW'(cx) * PW'(sy)));
			t1_s[2][1] <= sx;
			t1_s[2][2] <= rnd(PW'(cx) * PW'(cy));
			mz_s[0][0] <= cz;  mz_s[0][1] <= -sz; mz_s[0][2] <= '0;
			mz_s[1][0] <= sz;  mz_s[1][1] <= cz;  mz_s[1][2] <= '0;
			mz_s[2][0] <= '0;  mz_s[2][1] <= '0;  mz_s[2][2] <= one;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					logic signed [PW-1:0] sum;
					sum = '0;
					for (int k = 0; k < 3; k++)
						sum = sum + PW'(t1_s[i][k]) * PW'(mz_s[k][j]);
					m[i][j] <= rnd(sum);
				end
		end
	end
endmodule

/* src/exr_mvmul.sv */
// ----------------------------------------------------------------------------
// exr_mvmul: matrix times vector with rounding and saturation
// Products registered, then summed and saturated.
// ----------------------------------------------------------------------------
module exr_mvmul (
	input  logic                              clk,
	input  logic                              en,
	input  exr_pkg::coef_t [2:0][2:0]         m,
	input  logic signed [2:0][exr_pkg::DATA_BITS-1:0] v,
	output exr_pkg::res_t                     res
);
	localparam int F  = exr_pkg::FRAC;
	localparam int D  = exr_pkg::DATA_BITS;
	localparam int PW = D + exr_pkg::COEF_BITS + 3;
	localparam logic signed [PW-1:0] DMAX = (PW'(1) <<< (D - 1)) - PW'(1);
	localparam logic signed [PW-1:0] DMIN = -DMAX - PW'(1);

	logic signed [PW-1:0] p_s [3][3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					p_s[i][j] <= PW'(m[i][j]) * PW'(signed'(v[j]));
		end
	end

	// one exact rounded sum, same as splitting into high and low parts
	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [PW-1:0] r [3];
			logic signed [D-1:0]  o [3];
			logic                 sat;
			sat = 1'b0;
			for (int i = 0; i < 3; i++) begin
				r[i] = (p_s[i][0] + p_s[i][1] + p_s[i][2] + (PW'(1) <<< (F - 1))) >>> F;
				if (r[i] > DMAX) begin
					o[i] = {1'b0, {(D-1){1'b1}}}; sat = 1'b1;
				end else if (r[i] < DMIN) begin
					o[i] = {1'b1, {(D-1){1'b0}}}; sat = 1'b1;
				end else begin
					o[i] = D'(r[i]);
				end
			end
			res.out_x <= o[0];
			res.out_y <= o[1];
			res.out_z <= o[2];
			res.saturated <= sat;
		end
	end
endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Euler XYZ vector rotation unit
// Drives random and corner-case angle/vector requests with random idling on
// both channels, predicts each rotated vector with a bit-exact CORDIC and
// matrix model, and compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int LATENCY     = 36;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int FRAC        = exr_pkg::FRAC;
	localparam int CSTEPS      = exr_pkg::CORDIC_STEPS;
	localparam int DBITS       = exr_pkg::DATA_BITS;
	localparam int ONE_COEF    = 1 << FRAC;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	exr_pkg::req_t req;
	logic res_valid;
	logic res_ready;
	exr_pkg::res_t res;

	euler_xyz_vector_rotation_unit dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	// predicted rotated vectors, oldest first
	exr_pkg::res_t rotated_q[$];
	int   err_cnt;
	int   sent_cnt;
	int   got_cnt;
	int   sat_cnt;
	longint cycle_cnt;
	// when set, the receiver never stalls (final stretch)
	bit   steady;

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	// ------------------------------------------------------------------
	// predictor: cordic sine/cosine, matrix chain, vector product
	// ------------------------------------------------------------------
	function automatic longint atan_step(int i);
		longint t[CSTEPS] = '{
			64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
			64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
			64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
			64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
			64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
			64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};
		return t[i];
	endfunction

	function automatic void phase_sincos(input logic [31:0] phase, output longint c,
			output longint s);
		logic [1:0]  q;
		logic [31:0] ru;
		longint x, y, z, dx, dy, t;
		q  = 2'((phase + 32'h20000000) >> 30);
		ru = phase - {q, 30'b0};
		z  = longint'(signed'(ru));
		x  = 64'h26DD3B6A;
		y  = 0;
		for (int i = 0; i < CSTEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_step(i);
			end else begin
				x += dx; y -= dy; z += atan_step(i);
			end
		end
		c = (x + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
		s = (y + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
		// overshoot beyond unity is clamped
		if (c > ONE_COEF) c = ONE_COEF;
		if (c < -ONE_COEF) c = -ONE_COEF;
		if (s > ONE_COEF) s = ONE_COEF;
		if (s < -ONE_COEF) s = -ONE_COEF;
		case (q)
			2'd0: ;
			2'd1: begin t = c; c = -s; s = t; end
			2'd2: begin c = -c; s = -s; end
			default: begin t = c; c = s; s = -t; end
		endcase
	endfunction

	typedef longint mat3_t [3][3];

	function automatic mat3_t mat_product(mat3_t a, mat3_t b);
		mat3_t  o;
		longint acc;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
				o[i][j] = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
			end
		return o;
	endfunction

	function automatic exr_pkg::res_t rotate_vector(exr_pkg::req_t r);
		mat3_t  mx, my, mz, m;
		longint c, s, shi, slo, acc;
		longint v[3], hi[3], lo[3], o[3];
		logic [31:0] ph;
		exr_pkg::res_t e;
		longint dmax, dmin;
		dmax = (64'sd1 <<< (DBITS - 1)) - 1;
		dmin = -dmax - 1;
		ph = {r.angle_x, 16'b0};
		phase_sincos(ph, c, s);
		mx = '{'{ONE_COEF, 0, 0}, '{0, c, -s}, '{0, s, c}};
		ph = 32'd0 - {r.angle_y, 16'b0};
		phase_sincos(ph, c, s);
		my = '{'{c, 0, s}, '{0, ONE_COEF, 0}, '{-s, 0, c}};
		ph = 32'd0 - {r.angle_z, 16'b0};
		phase_sincos(ph, c, s);
		mz = '{'{c, -s, 0}, '{s, c, 0}, '{0, 0, ONE_COEF}};
		m = mat_product(mat_product(mx, my), mz);
		v[0] = r.vec_x; v[1] = r.vec_y; v[2] = r.vec_z;
		for (int j = 0; j < 3; j++) begin
			hi[j] = v[j] >>> 24;
			lo[j] = v[j] - hi[j] * (64'sd1 <<< 24);
		end
		e.saturated = 1'b0;
		for (int i = 0; i < 3; i++) begin
			shi = 0; slo = 0;
			for (int j = 0; j < 3; j++) begin
				shi += m[i][j] * hi[j];
				slo += m[i][j] * lo[j];
			end
			acc = shi * (64'sd1 <<< (24 - FRAC))
				+ ((slo + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
			if (acc > dmax) begin acc = dmax; e.saturated = 1'b1; end
			if (acc < dmin) begin acc = dmin; e.saturated = 1'b1; end
			o[i] = acc;
		end
		e.out_x = o[0][DBITS-1:0];
		e.out_y = o[1][DBITS-1:0];
		e.out_z = o[2][DBITS-1:0];
		return e;
	endfunction

	// ------------------------------------------------------------------
	// request driver
	// ------------------------------------------------------------------
	// send one request, optionally after a random idle burst; valid stays
	// up after acceptance until the next request or an idle period
	task automatic send_request(input exr_pkg::req_t r, input bit may_idle);
		if (may_idle && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		// prediction taken at acceptance
		do @(posedge clk); while (!req_ready);
		rotated_q.push_back(rotate_vector(r));
		sent_cnt++;
		@(negedge clk);
	endtask

	// signed component: corner values, small random values or, half the time, full random
	function automatic logic [31:0] pick_component();
		case ($urandom_range(0, 7))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
			3: return 32'h00010000;
			default: return $urandom;
		endcase
	endfunction

	function automatic exr_pkg::req_t random_request();
		exr_pkg::req_t r;
		r.angle_x = 16'($urandom);
		r.angle_y = 16'($urandom);
		r.angle_z = 16'($urandom);
		r.vec_x   = pick_component();
		r.vec_y   = pick_component();
		r.vec_z   = pick_component();
		return r;
	endfunction

	// ------------------------------------------------------------------
	// result checker and receiver idling
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		exr_pkg::res_t e;
		if (res_valid && res_ready) begin
			got_cnt++;
			if (rotated_q.size() == 0) begin
				$error("result with no request outstanding: %h", res);
				err_cnt++;
			end else begin
				e = rotated_q.pop_front();
				if (e.saturated) sat_cnt++;
				if (res.out_x !== e.out_x) begin
					$error("out_x expected %h actual %h", e.out_x, res.out_x);
					err_cnt++;
				end
				if (res.out_y !== e.out_y) begin
					$error("out_y expected %h actual %h", e.out_y, res.out_y);
					err_cnt++;
				end
				if (res.out_z !== e.out_z) begin
					$error("out_z expected %h actual %h", e.out_z, res.out_z);
					err_cnt++;
				end
				if (res.saturated !== e.saturated) begin
					$error("saturated expected %b actual %b", e.saturated,
						res.saturated);
					err_cnt++;
				end
			end
		end
	end

	// receiver stalls in random bursts, never in the final stretch
	initial begin
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!steady && $urandom_range(0, 9) == 0) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end
			res_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(negedge clk);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", rotated_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (rotated_q.size() != 0) @(negedge clk);
	endtask

	// zero angles, quadrant boundaries and extreme vectors
	task automatic test_directed();
		logic [15:0] ang[6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
			16'hFFFF, 16'h2000};
		exr_pkg::req_t r;
		for (int i = 0; i < 6; i++) begin
			r.angle_x = ang[i];
			r.angle_y = ang[(i + 1) % 6];
			r.angle_z = ang[(i + 3) % 6];
			r.vec_x = 32'h00010000; r.vec_y = 32'hFFFF0000; r.vec_z = 32'h00008000;
			send_request(r, 1'b0);
		end
		// extreme vectors test the saturation limits, with and without rotation
		r = '0;
		r.vec_x = 32'h7FFFFFFF; r.vec_y = 32'h7FFFFFFF; r.vec_z = 32'h7FFFFFFF;
		send_request(r, 1'b0);
		r.angle_x = 16'h2000; r.angle_y = 16'h2000; r.angle_z = 16'h2000;
		send_request(r, 1'b0);
		r.vec_x = 32'h80000000; r.vec_y = 32'h80000000; r.vec_z = 32'h80000000;
		send_request(r, 1'b0);
		r.angle_x = 16'hFFFF; r.angle_y = 16'hFFFF; r.angle_z = 16'hFFFF;
		send_request(r, 1'b0);
		r = '0;
		send_request(r, 1'b0);
		r = '1;
		send_request(r, 1'b0);
		r.vec_x = 32'h80000000; r.vec_y = 32'h7FFFFFFF; r.vec_z = 32'h00000001;
		r.angle_x = 16'h8000; r.angle_y = 16'h0001; r.angle_z = 16'h7FFF;
		send_request(r, 1'b0);
		// small residuals near the cordic split and the clamp
		r.angle_x = 16'h1FFF; r.angle_y = 16'h6000; r.angle_z = 16'hE000;
		r.vec_x = 32'h40000000; r.vec_y = 32'hC0000000; r.vec_z = 32'h12345678;
		send_request(r, 1'b0);
	endtask

	task automatic test_random(input int n);
		for (int i = 0; i < n; i++) begin
			send_request(random_request(), 1'b1);
			// halfway through, the sender holds off until the pipeline is empty
			if (i == n / 2) wait_drained();
		end
	endtask

	// back-to-back requests with no idling on either side
	task automatic test_streaming(input int n);
		steady = 1'b1;
		for (int i = 0; i < n; i++) send_request(random_request(), 1'b0);
	endtask

	initial begin
		err_cnt = 0; sent_cnt = 0; got_cnt = 0; sat_cnt = 0;
		cycle_cnt = 0; steady = 1'b0;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(1500);
		test_streaming(250);
		wait_drained();
		repeat (LATENCY + 10) @(negedge clk);
		$display("sent %0d requests, checked %0d results, %0d saturating",
			sent_cnt, got_cnt, sat_cnt);
		$display("covered quadrant angles, extreme vectors, random idling and streaming");
		if (err_cnt == 0 && rotated_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
